// ===== hdl/gyro_bias_calibrate_and_correct_macros.svh =====
// Assertion macros shared by the checker of the gyro bias calibrator.
// Depends on nothing; the user must have signals named clk and rst in scope.
`ifndef GYRO_BIAS_CALIBRATE_AND_CORRECT_MACROS_SVH
`define GYRO_BIAS_CALIBRATE_AND_CORRECT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define GBC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define GBC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/gbc_pkg.sv =====
// Package for the gyro bias calibrator: widths, codes, constants and shared types.
// Used by every RTL module of the block; depends on nothing.
package gbc_pkg;

  localparam int DATA_W              = 16;
  localparam int CFG_W               = 13;
  localparam int NUM_AXES            = 3;
  localparam int MAX_CAL_SAMPLES_DEF = 4096;

  localparam logic [CFG_W-1:0]         CAL_COUNT_RESET = CFG_W'(100);
  localparam logic signed [DATA_W-1:0] DATA_MAX        = 16'sh7FFF;
  localparam logic signed [DATA_W-1:0] DATA_MIN        = 16'sh8000;
  localparam logic [1:0]               AXIS_FIRST      = 2'd0;
  localparam logic [1:0]               AXIS_LAST       = 2'(NUM_AXES - 1);

  // Opcode of an input item.
  localparam logic OP_CAL  = 1'b0;
  localparam logic OP_MEAS = 1'b1;

  // Operation of the shared adder.
  typedef enum logic [2:0] {
    ALU_ACC = 3'b001,
    ALU_SUB = 3'b010,
    ALU_NEG = 3'b100
  } alu_op_t;

  // Sequencer states.
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_ACC   = 7'b0000010,
    S_CHECK = 7'b0000100,
    S_DIV   = 7'b0001000,
    S_DIVW  = 7'b0010000,
    S_CORR  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  // Status of the divider as seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== hdl/gbc_divider.sv =====
// Restoring divider for the gyro bias calibrator, one quotient bit per cycle.
// Depends on gbc_pkg for the status type.
module gbc_divider import gbc_pkg::*; #(
  parameter int DVD_W = 28,
  parameter int DVS_W = 13
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output div_stat_t        stat,
  output logic [DVD_W-1:0] quotient
);

  localparam int ITER_W = $clog2(DVD_W + 1);

  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [DVD_W-1:0] quo;
  logic [ITER_W-1:0] iter;
  logic busy;
  logic done;

  logic [DVS_W:0]   partial;
  logic [DVS_W+1:0] diff;
  logic             fits;

  // Shift the next dividend bit into the remainder and try the subtraction.
  always_comb begin
    partial = {rem, quo[DVD_W-1]};
    diff    = {1'b0, partial} - {2'b00, dvs};
    fits    = ~diff[DVS_W+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        iter <= ITER_W'(DVD_W);
      end else if (busy) begin
        iter <= iter - ITER_W'(1);
        if (iter == ITER_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= divisor;
      quo <= dividend;
    end else if (busy) begin
      rem <= fits ? diff[DVS_W-1:0] : partial[DVS_W-1:0];
      quo <= {quo[DVD_W-2:0], fits};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = quo;

endmodule

// ===== hdl/gyro_bias_calibrate_and_correct.sv =====
// Top level of the gyro bias calibrator: sequencer, shared adder and state registers.
// Depends on gbc_pkg and instantiates gbc_divider.

// Gyro bias calibration and correction. Each input transfer carries one three-axis sample
// and an opcode. A calibration sample (opcode 0) is added to per-axis running sums; when
// the number of summed samples reaches calibration_count (0 acts as 1, values above
// MAX_CAL_SAMPLES act as MAX_CAL_SAMPLES), each bias becomes its sum divided by the sample
// count, truncated toward zero, and the sums restart. That result has bias_updated set and
// zero corrected values; other calibration results are all zero. A measure sample (opcode
// 1) has the bias subtracted per axis, saturated to the signed 16-bit range. One item is
// in work at a time, and in_stall stays high while it is. The axes go one after another
// through a single shared adder: a measure item runs its three subtractions, a calibration
// item its three additions and then a check of the sample count. The item that completes a
// calibration then runs the three divisions, one after another, on one restoring divider
// that retires one quotient bit a cycle; its dividend is the sum magnitude, SUM_W =
// 16 + ceil(log2(MAX_CAL_SAMPLES)) bits wide. The result is loaded into the output register
// once that is free, and the block then returns to idle to take the next input. The result
// sits in an output register, so the next input can be accepted while it waits to be
// taken. calibration_count is written through its own valid/ready port, which is always
// ready; write it only while the block is idle. Reset is synchronous and clears biases and
// sums.
module gyro_bias_calibrate_and_correct import gbc_pkg::*; #(
  parameter int MAX_CAL_SAMPLES = MAX_CAL_SAMPLES_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  // Input channel.
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     opcode,
  input  logic signed [DATA_W-1:0] raw_x,
  input  logic signed [DATA_W-1:0] raw_y,
  input  logic signed [DATA_W-1:0] raw_z,
  // Output channel.
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] corrected_x,
  output logic signed [DATA_W-1:0] corrected_y,
  output logic signed [DATA_W-1:0] corrected_z,
  output logic                     bias_updated,
  // Configuration channel.
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_W-1:0]         calibration_count
);

  // The sample count never exceeds MAX_CAL_SAMPLES, and the sums grow by at most that
  // many 16-bit samples.
  localparam int CNT_W = $clog2(MAX_CAL_SAMPLES + 1);
  localparam int SUM_W = DATA_W + $clog2(MAX_CAL_SAMPLES);
  localparam int ALU_W = (SUM_W > DATA_W) ? SUM_W : DATA_W + 1;
  localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  localparam logic [CMP_W-1:0] MAX_CNT = CMP_W'(MAX_CAL_SAMPLES);
  localparam logic [SUM_W-1:0] POS_LIM = SUM_W'(2 ** (DATA_W - 1) - 1);
  localparam logic [SUM_W-1:0] NEG_LIM = SUM_W'(2 ** (DATA_W - 1));

  state_t state;
  logic [1:0] axis;

  logic [CFG_W-1:0]         cal_cnt;
  logic signed [DATA_W-1:0] raw_r  [NUM_AXES];
  logic signed [SUM_W-1:0]  sum_r  [NUM_AXES];
  logic signed [DATA_W-1:0] bias_r [NUM_AXES];
  logic signed [DATA_W-1:0] res_r  [NUM_AXES];
  logic [CNT_W-1:0]         samples;
  logic                     upd_r;
  logic                     neg_r;

  // Shared adder.
  alu_op_t                  alu_op;
  logic signed [DATA_W-1:0] raw_sel;
  logic signed [SUM_W-1:0]  sum_sel;
  logic signed [DATA_W-1:0] bias_sel;
  logic [ALU_W-1:0]         alu_a;
  logic [ALU_W-1:0]         alu_b;
  logic                     alu_cin;
  logic [ALU_W-1:0]         alu_y;
  logic signed [DATA_W-1:0] corr_sat;

  // Division.
  logic [CMP_W-1:0]         eff_cnt;
  logic                     cal_complete;
  logic                     div_start;
  logic [SUM_W-1:0]         div_dividend;
  logic [SUM_W-1:0]         div_quot;
  div_stat_t                div_stat;
  logic signed [DATA_W-1:0] bias_new;

  logic out_free;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign out_free  = ~out_valid | ~out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_cnt <= CAL_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cal_cnt <= calibration_count;
    end
  end

  // Effective count: zero acts as one, and the count is capped at MAX_CAL_SAMPLES.
  always_comb begin
    if (cal_cnt == '0) begin
      eff_cnt = CMP_W'(1);
    end else if (CMP_W'(cal_cnt) > MAX_CNT) begin
      eff_cnt = MAX_CNT;
    end else begin
      eff_cnt = CMP_W'(cal_cnt);
    end
    cal_complete = (CMP_W'(samples) >= eff_cnt);
  end

  // The sequencer state picks what the shared adder does for the current axis.
  always_comb begin
    raw_sel  = raw_r[axis];
    sum_sel  = sum_r[axis];
    bias_sel = bias_r[axis];
    priority if (state == S_ACC) begin
      alu_op = ALU_ACC;
    end else if (state == S_DIV) begin
      alu_op = ALU_NEG;
    end else begin
      alu_op = ALU_SUB;
    end
    unique case (alu_op)
      ALU_ACC: begin
        alu_a   = ALU_W'(sum_sel);
        alu_b   = ALU_W'(raw_sel);
        alu_cin = 1'b0;
      end
      ALU_NEG: begin
        alu_a   = '0;
        alu_b   = ~ALU_W'(sum_sel);
        alu_cin = 1'b1;
      end
      default: begin
        alu_a   = ALU_W'(raw_sel);
        alu_b   = ~ALU_W'(bias_sel);
        alu_cin = 1'b1;
      end
    endcase
    alu_y = alu_a + alu_b + ALU_W'(alu_cin);

    // The difference of two 16-bit values fits in 17 bits; saturate it back to 16.
    if (alu_y[DATA_W] != alu_y[DATA_W-1]) begin
      corr_sat = alu_y[DATA_W] ? DATA_MIN : DATA_MAX;
    end else begin
      corr_sat = alu_y[DATA_W-1:0];
    end

    div_dividend = sum_sel[SUM_W-1] ? alu_y[SUM_W-1:0] : sum_sel;
    div_start    = (state == S_DIV);
  end

  gbc_divider #(
    .DVD_W (SUM_W),
    .DVS_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (samples),
    .stat     (div_stat),
    .quotient (div_quot)
  );

  // Restore the sign of the quotient magnitude and keep it in the 16-bit range.
  always_comb begin
    if (neg_r) begin
      bias_new = (div_quot > NEG_LIM) ? DATA_MIN : -div_quot[DATA_W-1:0];
    end else begin
      bias_new = (div_quot > POS_LIM) ? DATA_MAX : div_quot[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      axis    <= AXIS_FIRST;
      samples <= '0;
      upd_r   <= 1'b0;
      for (int i = 0; i < NUM_AXES; i++) begin
        sum_r[i]  <= '0;
        bias_r[i] <= '0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            axis  <= AXIS_FIRST;
            upd_r <= 1'b0;
            state <= (opcode == OP_CAL) ? S_ACC : S_CORR;
          end
        end
        S_ACC: begin
          sum_r[axis] <= alu_y[SUM_W-1:0];
          if (axis == AXIS_LAST) begin
            axis    <= AXIS_FIRST;
            samples <= samples + CNT_W'(1);
            state   <= S_CHECK;
          end else begin
            axis <= axis + 2'd1;
          end
        end
        S_CHECK: begin
          state <= cal_complete ? S_DIV : S_DONE;
        end
        S_DIV: begin
          state <= S_DIVW;
        end
        S_DIVW: begin
          if (div_stat.done) begin
            bias_r[axis] <= bias_new;
            if (axis == AXIS_LAST) begin
              for (int i = 0; i < NUM_AXES; i++) begin
                sum_r[i] <= '0;
              end
              samples <= '0;
              upd_r   <= 1'b1;
              state   <= S_DONE;
            end else begin
              axis  <= axis + 2'd1;
              state <= S_DIV;
            end
          end
        end
        S_CORR: begin
          if (axis == AXIS_LAST) begin
            state <= S_DONE;
          end else begin
            axis <= axis + 2'd1;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Item payload and per-axis results; calibration items report zeros.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      raw_r[0] <= raw_x;
      raw_r[1] <= raw_y;
      raw_r[2] <= raw_z;
      for (int i = 0; i < NUM_AXES; i++) begin
        res_r[i] <= '0;
      end
    end else if (state == S_CORR) begin
      res_r[axis] <= corr_sat;
    end
    if (state == S_DIV) begin
      neg_r <= sum_sel[SUM_W-1];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      corrected_x  <= res_r[0];
      corrected_y  <= res_r[1];
      corrected_z  <= res_r[2];
      bias_updated <= upd_r;
    end
  end

endmodule

// ===== hdl/gbc_checker.sv =====
// Port-level checker for the gyro bias calibrator, bound to the top level.
// Depends on the assertion macros header and on gyro_bias_calibrate_and_correct.
`include "gyro_bias_calibrate_and_correct_macros.svh"

module gbc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] corrected_x,
  input logic [15:0] corrected_y,
  input logic [15:0] corrected_z,
  input logic        bias_updated
);

  // A result that is held back keeps its value.
  `GBC_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(corrected_x) && $stable(corrected_y) && $stable(corrected_z) && $stable(bias_updated), "stalled result changed")

  // A result that loaded new biases comes from a calibration sample and reports zeros.
  `GBC_ASSERT(a_upd_zero, out_valid && bias_updated |-> corrected_x == 16'd0 && corrected_y == 16'd0 && corrected_z == 16'd0, "bias update result is not zero")

  // Only one item is in work: after an input transfer the block holds off the next one.
  `GBC_ASSERT(a_one_item, in_valid && !in_stall |=> in_stall, "input accepted while busy")

  // Reset empties the output register.
  `GBC_ASSERT_ALWAYS(a_rst_out, rst |=> !out_valid, "result valid after reset")

endmodule

bind gyro_bias_calibrate_and_correct gbc_checker u_gbc_checker (.*);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for gyro_bias_calibrate_and_correct: bias averaging and correction.
// Depends on gbc_pkg and the RTL of the block; the expected results come from a model kept here.

module tb_top import gbc_pkg::*;;

  // The slowest correct gap between transfers is a calibration-completing item with its
  // three divisions, plus the longest receiver stall and the longest sender gap.
  localparam int QUIET_LIMIT  = 5000;
  localparam int RANDOM_ITEMS = 770;
  localparam int EXTREME_RUN  = 40;

  // One expected or observed result of the block.
  typedef struct {
    logic signed [DATA_W-1:0] axis [NUM_AXES];
    logic                     updated;
  } correction_t;

  // Keeps the running sums, the sample count, the biases and the calibration count
  // the same way the block does, and queues the result that each sample must produce.
  class bias_model;
    logic [CFG_W-1:0]         cal_count;
    longint                   axis_sum [NUM_AXES];
    longint                   samples_in_sum;
    logic signed [DATA_W-1:0] axis_bias [NUM_AXES];
    correction_t              pending_q [$];
    int                       mismatches;

    function new();
      cal_count = CAL_COUNT_RESET;
      for (int a = 0; a < NUM_AXES; a++) begin
        axis_sum[a]  = 0;
        axis_bias[a] = '0;
      end
      samples_in_sum = 0;
      mismatches     = 0;
    endfunction

    function void set_count(logic [CFG_W-1:0] v);
      cal_count = v;
    endfunction

    function int pending();
      return pending_q.size();
    endfunction

    // Zero behaves as one and anything past the bound as the bound.
    function longint target_count();
      longint n;
      n = longint'(cal_count);
      if (n == 0) n = 1;
      if (n > MAX_CAL_SAMPLES_DEF) n = MAX_CAL_SAMPLES_DEF;
      return n;
    endfunction

    function logic signed [DATA_W-1:0] clamp16(longint v);
      if (v < longint'(DATA_MIN)) return DATA_MIN;
      if (v > longint'(DATA_MAX)) return DATA_MAX;
      return DATA_W'(v);
    endfunction

    function void note_sample(logic op, logic signed [DATA_W-1:0] rx,
                              logic signed [DATA_W-1:0] ry, logic signed [DATA_W-1:0] rz);
      correction_t              c;
      logic signed [DATA_W-1:0] raw [NUM_AXES];
      raw[0] = rx;
      raw[1] = ry;
      raw[2] = rz;
      c.updated = 1'b0;
      if (op == OP_CAL) begin
        for (int a = 0; a < NUM_AXES; a++) begin
          axis_sum[a] += longint'(raw[a]);
          c.axis[a] = '0;
        end
        samples_in_sum++;
        // A lowered count completes on the next calibration sample and divides by
        // the samples actually summed; SystemVerilog division truncates toward zero.
        if (samples_in_sum >= target_count()) begin
          for (int a = 0; a < NUM_AXES; a++) begin
            axis_bias[a] = clamp16(axis_sum[a] / samples_in_sum);
            axis_sum[a]  = 0;
          end
          samples_in_sum = 0;
          c.updated      = 1'b1;
        end
      end else begin
        for (int a = 0; a < NUM_AXES; a++)
          c.axis[a] = clamp16(longint'(raw[a]) - longint'(axis_bias[a]));
      end
      pending_q.push_back(c);
    endfunction

    function void check_correction(logic signed [DATA_W-1:0] gx, logic signed [DATA_W-1:0] gy,
                                   logic signed [DATA_W-1:0] gz, logic gu);
      correction_t              want;
      logic signed [DATA_W-1:0] got [NUM_AXES];
      string                    names [NUM_AXES];
      names  = '{"corrected_x", "corrected_y", "corrected_z"};
      got[0] = gx;
      got[1] = gy;
      got[2] = gz;
      if (pending_q.size() == 0) begin
        $error("result transfer with nothing expected: %0d %0d %0d %0b", gx, gy, gz, gu);
        mismatches++;
        return;
      end
      want = pending_q.pop_front();
      for (int a = 0; a < NUM_AXES; a++) begin
        if (got[a] !== want.axis[a]) begin
          $error("%s: expected %0d, actual %0d", names[a], want.axis[a], got[a]);
          mismatches++;
        end
      end
      if (gu !== want.updated) begin
        $error("bias_updated: expected %0b, actual %0b", want.updated, gu);
        mismatches++;
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     opcode = OP_CAL;
  logic signed [DATA_W-1:0] raw_x = '0;
  logic signed [DATA_W-1:0] raw_y = '0;
  logic signed [DATA_W-1:0] raw_z = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DATA_W-1:0] corrected_x;
  logic signed [DATA_W-1:0] corrected_y;
  logic signed [DATA_W-1:0] corrected_z;
  logic                     bias_updated;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_W-1:0]         calibration_count = '0;

  bias_model model = new();

  // Idling controls: no_idle removes sender gaps, rx_calm removes receiver stalls.
  bit no_idle = 1'b0;
  bit rx_calm = 1'b0;
  int stall_left = 0;
  int quiet_cycles = 0;

  gyro_bias_calibrate_and_correct uut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .opcode            (opcode),
    .raw_x             (raw_x),
    .raw_y             (raw_y),
    .raw_z             (raw_z),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .corrected_x       (corrected_x),
    .corrected_y       (corrected_y),
    .corrected_z       (corrected_z),
    .bias_updated      (bias_updated),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .calibration_count (calibration_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: runs of ready cycles alternate with stalls, mostly short and now and then
  // long, so that stalls land on every cycle of the block's sequence.
  always @(negedge clk) begin
    int r;
    if (stall_left > 0) begin
      stall_left--;
    end else begin
      r = $urandom_range(0, 99);
      if (rx_calm || r < 55) begin
        out_stall  <= 1'b0;
        stall_left = $urandom_range(0, 12);
      end else if (r < 92) begin
        out_stall  <= 1'b1;
        stall_left = $urandom_range(0, 3);
      end else begin
        out_stall  <= 1'b1;
        stall_left = $urandom_range(10, 40);
      end
    end
  end

  // Monitor: every result transfer is checked against the oldest expectation, and every
  // input transfer adds a new expectation. Outputs are sampled at the rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall)
        model.check_correction(corrected_x, corrected_y, corrected_z, bias_updated);
      if (in_valid && !in_stall)
        model.note_sample(opcode, raw_x, raw_y, raw_z);
    end
  end

  // Watchdog: ends the run if no transfer of any kind happens for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // Axis values: a few extremes, many full-range words, many near zero so that
  // biases stay moderate and corrections land on both sides of saturation.
  function automatic logic signed [DATA_W-1:0] rand_axis();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      case ($urandom_range(0, 3))
        0:       return DATA_MIN;
        1:       return DATA_MAX;
        2:       return '0;
        default: return '1;
      endcase
    end
    if (r < 50) return DATA_W'($urandom());
    return DATA_W'(int'($urandom_range(0, 4000)) - 2000);
  endfunction

  // Drives one sample and holds it until the transfer happens. Entered and left at a
  // falling edge with no update of in_valid pending in that time step.
  task automatic send_sample(input logic op, input logic signed [DATA_W-1:0] x,
                             input logic signed [DATA_W-1:0] y,
                             input logic signed [DATA_W-1:0] z);
    int gap;
    gap = pick_gap();
    in_valid <= 1'b1;
    opcode   <= op;
    raw_x    <= x;
    raw_y    <= y;
    raw_z    <= z;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Holds the sender off until every expected result has been taken.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (model.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Writes the calibration count; only called with the block idle.
  task automatic write_cal_count(input logic [CFG_W-1:0] v);
    cfg_valid         <= 1'b1;
    calibration_count <= v;
    do @(posedge clk); while (!cfg_ready);
    model.set_count(v);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    int               sent;
    int               phase_len;
    int               r;
    logic [CFG_W-1:0] new_count;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part. With the reset biases of zero, a measure passes through untouched,
    // and a calibration sample under the reset count of 100 does not complete.
    send_sample(OP_MEAS, DATA_MAX, DATA_MIN, 16'sd0);
    send_sample(OP_MEAS, -16'sd1, 16'sd1, 16'sd12345);
    send_sample(OP_CAL, 16'sd100, -16'sd100, 16'sd7);
    wait_for_drain();

    // Lowering the count to one completes on the next sample, averaging two samples.
    // A second count-of-one calibration loads the most extreme biases; the first measure
    // after it saturates at both ends of the range and the second gives zeros.
    write_cal_count(CFG_W'(1));
    send_sample(OP_CAL, DATA_MIN, DATA_MAX, -16'sd3);
    send_sample(OP_CAL, DATA_MIN, DATA_MAX, DATA_MIN);
    send_sample(OP_MEAS, DATA_MAX, DATA_MIN, 16'sd0);
    send_sample(OP_MEAS, DATA_MIN, DATA_MAX, DATA_MIN);
    wait_for_drain();

    // A count of zero behaves as one.
    write_cal_count(CFG_W'(0));
    send_sample(OP_CAL, DATA_MAX, DATA_MIN, -16'sd7);
    send_sample(OP_MEAS, DATA_MIN, DATA_MAX, 16'sd100);
    wait_for_drain();

    // Partial sums under a large count, then a lower count: the next calibration sample
    // completes with four samples, and negative sums truncate toward zero.
    write_cal_count(CFG_W'(3));
    send_sample(OP_CAL, -16'sd7, -16'sd7, 16'sd5);
    send_sample(OP_CAL, -16'sd6, 16'sd0, 16'sd5);
    wait_for_drain();
    write_cal_count(CFG_W'(4096));
    send_sample(OP_CAL, 16'sd1, 16'sd1, 16'sd1);
    wait_for_drain();
    write_cal_count(CFG_W'(2));
    send_sample(OP_CAL, 16'sd0, -16'sd1, 16'sd2);
    send_sample(OP_MEAS, 16'sd0, 16'sd0, 16'sd0);
    wait_for_drain();

    // Small averages that truncate to zero.
    write_cal_count(CFG_W'(3));
    send_sample(OP_CAL, -16'sd1, -16'sd2, 16'sd1);
    send_sample(OP_CAL, -16'sd1, 16'sd0, 16'sd0);
    send_sample(OP_CAL, 16'sd0, 16'sd0, 16'sd0);
    send_sample(OP_MEAS, 16'sd5, -16'sd5, 16'sd0);
    wait_for_drain();

    // The largest count is clamped to the bound, so a back-to-back run of extreme samples
    // does not complete. Lowering the count to one then averages the whole run into the
    // most extreme x and y biases, and the first measure after it saturates on those axes.
    write_cal_count('1);
    no_idle = 1'b1;
    rx_calm = 1'b1;
    for (int i = 0; i < EXTREME_RUN; i++)
      send_sample(OP_CAL, DATA_MIN, DATA_MAX, rand_axis());
    no_idle = 1'b0;
    rx_calm = 1'b0;
    wait_for_drain();
    write_cal_count(CFG_W'(1));
    send_sample(OP_CAL, DATA_MIN, DATA_MAX, rand_axis());
    send_sample(OP_MEAS, DATA_MAX, DATA_MIN, rand_axis());
    send_sample(OP_MEAS, DATA_MIN, DATA_MAX, rand_axis());
    wait_for_drain();

    // Random phases. Each starts from an idle block with a new count; partial sums carry
    // over, so a lower count often cuts a calibration short. Calibration samples dominate
    // so that completions are frequent under small counts.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 10)      new_count = '0;
      else if (r < 65) new_count = CFG_W'($urandom_range(1, 12));
      else if (r < 80) new_count = CFG_W'($urandom_range(13, 64));
      else if (r < 88) new_count = CFG_W'($urandom_range(4096, 8191));
      else             new_count = CFG_W'(1);
      write_cal_count(new_count);
      no_idle   = ($urandom_range(0, 4) == 0);
      rx_calm   = ($urandom_range(0, 4) == 0);
      phase_len = $urandom_range(20, 70);
      for (int i = 0; i < phase_len; i++) begin
        send_sample(($urandom_range(0, 99) < 65) ? OP_CAL : OP_MEAS,
                    rand_axis(), rand_axis(), rand_axis());
        sent++;
      end
      wait_for_drain();
    end

    // The drain above already emptied the queue; the extra cycles catch stray results.
    repeat (120) @(posedge clk);
    if (model.mismatches == 0 && model.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== gyro_bias_calibrate_and_correct.f =====
+incdir+hdl
hdl/gbc_pkg.sv
hdl/gbc_divider.sv
hdl/gyro_bias_calibrate_and_correct.sv
hdl/gbc_checker.sv
tb/tb_top.sv
